/* rtl/core/smf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_pkg: shared types and constants of the sliding median filter
// Beat payloads, configuration register format and sequencer states.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned RADIUS_W = 4;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd2;

  // per-sequence emitted counter saturates here
  localparam int unsigned EMIT_W = 6;
  localparam logic [EMIT_W-1:0] EMIT_MAX = 6'd63;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                is_final;
  } smf_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] median_value;
    logic                is_final_out;
  } smf_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GATHER,
    ST_RANK,
    ST_EVAL
  } smf_state_e;

endpackage

/* rtl/core/sliding_median_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_median_filter: clipped-window median over a stream of pitch samples
// For every position p the block returns the median of the samples at
// p-R..p+R (R = window_radius, saturated to MAX_RADIUS), with the window cut
// short at both ends of the sequence; for an even window size n the element
// of rank n/2 (upper middle) is chosen. Results lag the input by R beats and
// the beat flagged is_final flushes every owed position, the last one with
// is_final_out set; the next input beat then starts a new sequence. An input
// beat is accepted and then followed by the closing check; each result it
// releases is checked, its window is gathered from the sample ring, and one
// to n candidates are ranked in turn against the window, where n is the
// clipped window size (at most 2*MAX_RADIUS+1). The single compare unit
// ranks one window entry per cycle, and a result may wait on a stalled
// output register. in_stall_o stays high from the cycle after acceptance
// through the closing check that follows the last result of that beat, and
// the radius register is writable only while the block is idle.
// ----------------------------------------------------------------------------
module sliding_median_filter
  import smf_pkg::*;
#(
  parameter int unsigned MAX_RADIUS   = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // radius register write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [RADIUS_W-1:0] cfg_data_i,
  // sample beats in
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  smf_in_t             in_data_i,
  // median beats out
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output smf_out_t            out_data_o
);

  localparam int unsigned DEPTH = 2 * MAX_RADIUS + 1;     // ring slots
  localparam int unsigned AW    = $clog2(DEPTH);          // ring address
  localparam int unsigned CW    = $clog2(DEPTH + 1);      // 0..DEPTH counts
  localparam int unsigned NW    = $clog2(MAX_RADIUS + 2); // results per beat
  localparam int unsigned XW    = CW + 2;                 // slot arithmetic

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  smf_state_e              state_q, state_d;
  logic [RADIUS_W-1:0]     radius_q;
  logic [AW-1:0]           wp_q, wp_d;            // next ring slot to write
  logic [CW-1:0]           pending_q, pending_d;  // received, not yet emitted
  logic [EMIT_W-1:0]       emitted_q, emitted_d;  // emitted in this sequence
  logic                    final_q, final_d;      // current beat closes sequence
  logic [NW-1:0]           count_q, count_d;      // results of current beat

  // per-result working set
  logic [CW-1:0]           n_q, n_d;              // clipped window size
  logic [CW-1:0]           k_q, k_d;              // wanted rank, n/2
  logic [AW-1:0]           rd_addr_q, rd_addr_d;
  logic [CW-1:0]           gidx_q, gidx_d;        // gather step
  logic [CW-1:0]           ci_q, ci_d;            // compare step in a pass
  logic [CW-1:0]           lt_q, lt_d;            // entries below candidate
  logic [CW-1:0]           le_q, le_d;            // entries not above candidate
  logic [SAMPLE_W-1:0]     cand_q, cand_d;
  logic [SAMPLE_W-1:0]     win_q [DEPTH];
  logic [SAMPLE_W-1:0]     win_d [DEPTH];
  logic [SAMPLE_W-1:0]     win_rot [DEPTH];

  // sample ring
  logic [SAMPLE_W-1:0]     ring_mem [DEPTH];
  logic [SAMPLE_W-1:0]     rd_data_q;
  logic [SAMPLE_W-1:0]     wr_data;
  logic [31:0]             sample_ext;

  // output register
  logic                    out_valid_q;
  smf_out_t                out_data_q;
  logic                    out_load;
  logic                    out_free;
  logic [31:0]             cand_ext;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  logic in_acc;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // samples are zero-extended and cut back to SAMPLE_W bits
  assign sample_ext = 32'(in_data_i.sample);
  assign wr_data    = sample_ext[SAMPLE_W-1:0];
  assign cand_ext   = 32'(cand_q);

  // --------------------------------------------------------------------------
  // Window geometry for the next owed position
  // --------------------------------------------------------------------------
  logic [CW-1:0] radius_eff;
  logic [CW-1:0] left_len;
  logic [CW-1:0] right_len;
  logic [CW-1:0] pend_m1;
  logic [CW-1:0] n_new;
  logic [XW-1:0] base_back;     // distance back to the window's oldest entry
  logic [XW-1:0] slot_diff;
  logic [AW-1:0] start_addr;
  logic          chk_go;

  always_comb begin
    radius_eff = (32'(radius_q) > MAX_RADIUS) ? CW'(MAX_RADIUS) : CW'(radius_q);
    left_len   = (8'(emitted_q) < 8'(radius_eff)) ? CW'(emitted_q) : radius_eff;
    pend_m1    = pending_q - CW'(1);
    // final flush clips the right side to what has arrived
    right_len  = (final_q && (pend_m1 < radius_eff)) ? pend_m1 : radius_eff;
    n_new      = left_len + right_len + CW'(1);
    base_back  = XW'(pending_q) + XW'(left_len);
    slot_diff  = XW'(wp_q) + XW'(DEPTH) - base_back;
    if (slot_diff >= XW'(DEPTH)) begin
      slot_diff = slot_diff - XW'(DEPTH);
    end
    start_addr = AW'(slot_diff);
    chk_go     = (pending_q != '0) && (final_q || (pending_q > radius_eff)) &&
                 (count_q < NW'(MAX_RADIUS + 1));
  end

  // --------------------------------------------------------------------------
  // Shared compare unit and window rotation
  // --------------------------------------------------------------------------
  logic [SAMPLE_W-1:0]     cand_cur;
  logic                    cmp_lt;
  logic                    cmp_le;
  logic                    rank_hit;

  assign cand_cur = (ci_q == '0) ? win_q[0] : cand_q;
  assign cmp_lt   = (win_q[0] < cand_cur);
  assign cmp_le   = (win_q[0] <= cand_cur);
  assign rank_hit = (lt_q <= k_q) && (k_q < le_q);

  // rotate the first n entries by one so each entry passes tap 0 in turn
  always_comb begin
    for (int k = 0; k < DEPTH - 1; k++) begin
      win_rot[k] = (CW'(k) == n_q - CW'(1)) ? win_q[0] : win_q[k+1];
    end
    win_rot[DEPTH-1] = win_q[0];
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic [CW-1:0] gidx_m1;

  assign gidx_m1 = gidx_q - CW'(1);

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    pending_d = pending_q;
    emitted_d = emitted_q;
    final_d   = final_q;
    count_d   = count_q;
    n_d       = n_q;
    k_d       = k_q;
    rd_addr_d = rd_addr_q;
    gidx_d    = gidx_q;
    ci_d      = ci_q;
    lt_d      = lt_q;
    le_d      = le_q;
    cand_d    = cand_q;
    win_d     = win_q;
    out_load  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          wp_d      = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
          pending_d = (pending_q < CW'(DEPTH)) ? pending_q + CW'(1) : pending_q;
          final_d   = in_data_i.is_final;
          count_d   = '0;
          state_d   = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (chk_go) begin
          n_d       = n_new;
          k_d       = n_new >> 1;
          rd_addr_d = start_addr;
          gidx_d    = '0;
          state_d   = ST_GATHER;
        end else begin
          if (final_q) begin
            pending_d = '0;
            emitted_d = '0;
          end
          state_d = ST_IDLE;
        end
      end

      ST_GATHER: begin
        // ring read port is registered: data arrives in the cycle after its address
        if (gidx_q != '0) begin
          win_d[gidx_m1[AW-1:0]] = rd_data_q;
        end
        rd_addr_d = (rd_addr_q == AW'(DEPTH - 1)) ? '0 : rd_addr_q + AW'(1);
        gidx_d    = gidx_q + CW'(1);
        if (gidx_q == n_q) begin
          ci_d    = '0;
          lt_d    = '0;
          le_d    = '0;
          state_d = ST_RANK;
        end
      end

      ST_RANK: begin
        if (ci_q == '0) begin
          cand_d = win_q[0];
        end
        lt_d  = lt_q + CW'(cmp_lt);
        le_d  = le_q + CW'(cmp_le);
        win_d = win_rot;
        ci_d  = ci_q + CW'(1);
        if (ci_q == n_q - CW'(1)) begin
          state_d = ST_EVAL;
        end
      end

      ST_EVAL: begin
        if (rank_hit) begin
          if (out_free) begin
            out_load  = 1'b1;
            pending_d = pending_q - CW'(1);
            emitted_d = (emitted_q != EMIT_MAX) ? emitted_q + EMIT_W'(1) : emitted_q;
            count_d   = count_q + NW'(1);
            state_d   = ST_CHECK;
          end
        end else begin
          // next candidate
          win_d   = win_rot;
          ci_d    = '0;
          lt_d    = '0;
          le_d    = '0;
          state_d = ST_RANK;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radius_q    <= RADIUS_RESET;
      wp_q        <= '0;
      pending_q   <= '0;
      emitted_q   <= '0;
      final_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      pending_q <= pending_d;
      emitted_q <= emitted_d;
      final_q   <= final_d;
      count_q   <= count_d;
      if (cfg_valid_i && cfg_ready_o) begin
        radius_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    k_q       <= k_d;
    rd_addr_q <= rd_addr_d;
    gidx_q    <= gidx_d;
    ci_q      <= ci_d;
    lt_q      <= lt_d;
    le_q      <= le_d;
    cand_q    <= cand_d;
    win_q     <= win_d;
    if (out_load) begin
      out_data_q.median_value <= cand_ext[SAMPLE_W-1:0];
      out_data_q.is_final_out <= final_q && (pending_q == CW'(1));
    end
  end

  // sample ring: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ring_mem[wp_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= ring_mem[rd_addr_q];
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q < AW'(DEPTH))
    else $error("ring write pointer out of range");

  a_window_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GATHER) |-> (n_q != '0 && n_q <= CW'(DEPTH) && k_q < n_q))
    else $error("window size or rank out of range");

  a_rank_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RANK) |-> (ci_q < n_q))
    else $error("compare step beyond window");

  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> (lt_q <= le_q && le_q <= n_q && le_q != '0))
    else $error("rank counts inconsistent");

  a_seq_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK && final_q && !chk_go) |=>
      (pending_q == '0 && emitted_q == '0 && state_q == ST_IDLE))
    else $error("sequence counters not cleared after final beat");

endmodule
